FILE: rtl/dca_pkg.sv
// shared types and constants for the descriptor chain allocator
`timescale 1ns / 1ps
`default_nettype none

package dca_pkg;

  // request operation codes
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  // fixed field widths of the request and response
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned HEAD_W  = 5;

endpackage

`default_nettype wire

FILE: rtl/descriptor_chain_allocator.sv
// descriptor chain allocator: used bitmap, continue marks and a link memory
//
//   channel   signals                          direction  width
//   request   valid ready func count head_index  in         1/8/5
//   response  out_valid out_ready ok first_entry out        1/5
//
// allocate: a check on acceptance, then S_ALLOC scans the entries in order up to the lowest
//   entry that completes the chain (at most QUEUE_DEPTH), then S_RESP responds
// free: each chain entry is visited in S_VISIT, then its link is read in S_LINK, then S_RESP responds
// failed allocate and out-of-range free go from the check straight to S_RESP
// reset clears the used bitmap and the continue marks and sets the free count to the depth
// a new request is taken while an earlier response still waits for out_ready
`timescale 1ns / 1ps
`default_nettype none

module descriptor_chain_allocator #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          valid,
  output logic                         ready,
  input  wire                          func,
  input  wire  [dca_pkg::COUNT_W-1:0]  count,
  input  wire  [dca_pkg::HEAD_W-1:0]   head_index,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         ok,
  output logic [dca_pkg::HEAD_W-1:0]   first_entry
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EXT_W = (IDX_W > dca_pkg::HEAD_W) ? IDX_W : dca_pkg::HEAD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_VISIT,
    S_LINK,
    S_RESP
  } state_t;

  state_t state;

  logic [QUEUE_DEPTH-1:0] used_map;
  logic [QUEUE_DEPTH-1:0] cont_mark;
  logic [CNT_W-1:0]       free_cnt;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] prev_idx;
  logic [IDX_W-1:0] new_head;
  logic [IDX_W-1:0] walk_idx;
  logic [CNT_W-1:0] taken;
  logic [CNT_W-1:0] want;
  logic             ok_pend;

  // link memory, written while a chain is built, read while it is walked
  logic [IDX_W-1:0] link_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] link_rd;
  logic             mem_we;

  logic             accept;
  logic             alloc_bad;
  logic             take_now;
  logic             last_take;
  logic [EXT_W-1:0] head_in_ext;
  logic [EXT_W-1:0] head_out_ext;
  logic             head_in_range;

  assign ready    = (state == S_IDLE);
  assign accept   = valid && ready;

  assign alloc_bad = (count == '0) || (32'(count) > QUEUE_DEPTH) ||
                     (32'(count) > 32'(free_cnt));

  assign head_in_ext   = EXT_W'(head_index);
  assign head_in_range = (32'(head_index) < QUEUE_DEPTH);
  assign head_out_ext  = EXT_W'(new_head);

  assign take_now  = !used_map[scan_idx];
  assign last_take = take_now && ((taken + CNT_W'(1)) == want);
  assign mem_we    = (state == S_ALLOC) && take_now && (taken != '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[prev_idx] <= scan_idx;
    end
    if (state == S_VISIT) begin
      link_rd <= link_mem[walk_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used_map  <= '0;
      cont_mark <= '0;
      free_cnt  <= CNT_W'(QUEUE_DEPTH);
      out_valid <= 1'b0;
      ok        <= 1'b0;
      first_entry <= '0;
      ok_pend   <= 1'b0;
      scan_idx  <= '0;
      prev_idx  <= '0;
      new_head  <= '0;
      walk_idx  <= '0;
      taken     <= '0;
      want      <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            new_head <= '0;
            scan_idx <= '0;
            taken    <= '0;
            want     <= CNT_W'(count);
            walk_idx <= head_in_ext[IDX_W-1:0];
            if (dca_pkg::func_t'(func) == dca_pkg::FUNC_ALLOC) begin
              ok_pend <= !alloc_bad;
              state   <= alloc_bad ? S_RESP : S_ALLOC;
            end else begin
              ok_pend <= 1'b1;
              state   <= head_in_range ? S_VISIT : S_RESP;
            end
          end
        end

        S_ALLOC: begin
          if (take_now) begin
            used_map[scan_idx]  <= 1'b1;
            cont_mark[scan_idx] <= 1'b0;
            free_cnt            <= free_cnt - CNT_W'(1);
            if (taken == '0) begin
              new_head <= scan_idx;
            end else begin
              cont_mark[prev_idx] <= 1'b1;
            end
            prev_idx <= scan_idx;
            taken    <= taken + CNT_W'(1);
          end
          if (last_take) begin
            state    <= S_RESP;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end

        S_VISIT: begin
          used_map[walk_idx] <= 1'b0;
          if (used_map[walk_idx]) begin
            free_cnt <= free_cnt + CNT_W'(1);
          end
          if (cont_mark[walk_idx]) begin
            cont_mark[walk_idx] <= 1'b0;
            state <= S_LINK;
          end else begin
            state <= S_RESP;
          end
        end

        S_LINK: begin
          // links are only ever written with in-range indexes
          walk_idx <= link_rd;
          state    <= S_VISIT;
        end

        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            ok          <= ok_pend;
            first_entry <= head_out_ext[dca_pkg::HEAD_W-1:0];
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // free count tracks the bitmap
  a_free_cnt: assert property (@(posedge clk) disable iff (rst)
    $countones(~used_map) == 32'(free_cnt))
    else $error("free count out of step with used bitmap");

  // a chain build never overshoots the requested length
  a_no_overshoot: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |-> taken < want)
    else $error("allocate scan took too many entries");

  // a rejected allocate goes straight to a failing response
  a_alloc_fail: assert property (@(posedge clk) disable iff (rst)
    accept && !func && alloc_bad |=> state == S_RESP && !ok_pend)
    else $error("rejected allocate did not fail");

  // the free walk stays inside the table
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    state == S_VISIT |-> 32'(walk_idx) < QUEUE_DEPTH)
    else $error("free walk left the table");

endmodule

`default_nettype wire
